>>> design/stkeval_pkg.sv
// Shared types and constants for the stack expression evaluator.
// Item structs, character codes, status codes and the cell control struct.
// Depends on nothing; other files use it by scoped names or by import.
package stkeval_pkg;

	localparam int DATA_W          = 32;
	localparam int STACK_DEPTH_DEF = 64;
	localparam int CNT_W           = $clog2(DATA_W);

	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_UNDERFLOW = 3'd1;
	localparam logic [2:0] ST_DIVZERO   = 3'd2;
	localparam logic [2:0] ST_OVERFLOW  = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;

	typedef struct packed {
		logic [7:0] symbol;
		logic       end_of_expr;
	} in_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [2:0]               status;
		logic [6:0]               leftover_depth;
	} out_item_t;

	// Shift command for one stack cell: load from the neighbor above, or below.
	typedef struct packed {
		logic take_prev;
		logic take_next;
	} cell_ctl_t;

endpackage

>>> design/stkeval_cell.sv
// One entry of the shifting operand stack.
// Loads from the cell above on a push, from the cell below on a pop.
// Depends on stkeval_pkg.
module stkeval_cell (
	input  logic                            clk,
	input  stkeval_pkg::cell_ctl_t          ctl,
	input  logic [stkeval_pkg::DATA_W-1:0]  prev,
	input  logic [stkeval_pkg::DATA_W-1:0]  next,
	output logic [stkeval_pkg::DATA_W-1:0]  q
);

	logic [stkeval_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctl.take_prev) begin
			data_q <= prev;
		end else if (ctl.take_next) begin
			data_q <= next;
		end
	end

	assign q = data_q;

endmodule

>>> design/stkeval_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Works on magnitudes and fixes the sign at the end; divisor must be nonzero.
// Depends on stkeval_pkg.
module stkeval_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [stkeval_pkg::DATA_W-1:0]  dividend,
	input  logic [stkeval_pkg::DATA_W-1:0]  divisor,
	output logic                            done,
	output logic [stkeval_pkg::DATA_W-1:0]  quotient
);

	localparam int W = stkeval_pkg::DATA_W;

	logic                          busy_q;
	logic                          done_q;
	logic [stkeval_pkg::CNT_W-1:0] cnt_q;
	logic [W-1:0]                  rem_q;
	logic [W-1:0]                  quo_q;
	logic [W-1:0]                  mb_q;
	logic                          neg_q;
	logic [W:0]                    shifted;
	logic [W:0]                    diff;

	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, mb_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= stkeval_pkg::CNT_W'(W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[W-1] ? (~dividend + 1'b1) : dividend;
			mb_q  <= divisor[W-1] ? (~divisor + 1'b1) : divisor;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			// Restoring step: keep the trial difference when it does not go negative
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

>>> design/stack_expression_evaluator.sv
// Top level of the stack expression evaluator: control, cell row, divider.
// Depends on stkeval_pkg, stkeval_cell and stkeval_div.
//
// Evaluates a postfix expression (notation_mode 0, characters left to right)
// or a prefix expression (notation_mode 1, characters fed right to left), one
// ASCII character per item. Digits push, + - * / pop two and push one with
// 32-bit wrapping arithmetic; other characters are ignored. The operand stack
// is a row of STACK_DEPTH identical cells that shift toward the bottom on a
// push and toward the top on a pop, so the top of stack is always the first
// cell. An item is taken only while the controller is idle: a digit or an
// ignored character is done on acceptance, + - * pass through S_ALU, and /
// goes through accept, operand check, the radix-2 divider loop (one step per
// quotient bit, the worst-case rate) and write back. An end_of_expr item then
// passes through S_EMIT to hand its result to the output register, and waits
// there while an earlier result has not been taken. The result carries the top
// of stack (0 if empty), a sticky status (first error of the expression, else
// empty or ok) and the depth saturated at 127; stack and error then clear. The
// user writes notation_mode via cfg_we/cfg_wdata while idle (not enforced).
module stack_expression_evaluator #(
	parameter int STACK_DEPTH = stkeval_pkg::STACK_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  stkeval_pkg::in_item_t  item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output stkeval_pkg::out_item_t result,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata
);

	localparam int W       = stkeval_pkg::DATA_W;
	localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_ALU  = 4'b0010,
		S_DIV  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t                 state_q, state_d;
	logic [DEPTH_W-1:0]     depth_q, depth_d;
	logic [2:0]             err_q, err_d;
	logic                   mode_q;
	logic [7:0]             op_q;
	logic                   last_q;
	logic                   out_valid_q;
	stkeval_pkg::out_item_t out_q;

	logic [W-1:0]           cells [STACK_DEPTH];
	stkeval_pkg::cell_ctl_t top_ctl, rest_ctl;
	logic [W-1:0]           top_in;

	logic                   accept;
	logic                   is_digit, is_op, full;
	logic [W-1:0]           first, second, lhs, rhs;
	logic [W-1:0]           prod, alu_res;
	logic                   underflow;
	logic                   div_start, div_done;
	logic [W-1:0]           quotient;
	logic                   apply_en;
	logic [W-1:0]           apply_val;
	logic [2:0]             alu_err;
	logic                   emit;
	logic [31:0]            depth_wide;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;

	assign is_digit = (item.symbol >= stkeval_pkg::CH_0) && (item.symbol <= stkeval_pkg::CH_9);
	assign is_op    = (item.symbol == stkeval_pkg::CH_PLUS) ||
	                  (item.symbol == stkeval_pkg::CH_MINUS) ||
	                  (item.symbol == stkeval_pkg::CH_STAR) ||
	                  (item.symbol == stkeval_pkg::CH_SLASH);
	assign full     = (depth_q == DEPTH_W'(STACK_DEPTH));

	// Missing operands read as zero; prefix mode swaps the operand roles
	assign first     = (depth_q != '0) ? cells[0] : '0;
	assign second    = (depth_q > DEPTH_W'(1)) ? cells[1] : '0;
	assign lhs       = mode_q ? first : second;
	assign rhs       = mode_q ? second : first;
	assign underflow = (depth_q < DEPTH_W'(2));
	assign prod      = lhs * rhs;

	always_comb begin
		unique case (op_q)
			stkeval_pkg::CH_PLUS:  alu_res = lhs + rhs;
			stkeval_pkg::CH_MINUS: alu_res = lhs - rhs;
			stkeval_pkg::CH_STAR:  alu_res = prod;
			default:               alu_res = '0; // divide by zero
		endcase
	end

	// Underflow is found before the divide-by-zero check
	always_comb begin
		if (underflow) begin
			alu_err = stkeval_pkg::ST_UNDERFLOW;
		end else if ((op_q == stkeval_pkg::CH_SLASH) && (rhs == '0)) begin
			alu_err = stkeval_pkg::ST_DIVZERO;
		end else begin
			alu_err = stkeval_pkg::ST_OK;
		end
	end

	assign div_start = (state_q == S_ALU) && (op_q == stkeval_pkg::CH_SLASH) && (rhs != '0);
	assign emit      = (state_q == S_EMIT) && (!out_valid_q || result_ready);

	always_comb begin
		state_d   = state_q;
		depth_d   = depth_q;
		err_d     = err_q;
		top_ctl   = '0;
		rest_ctl  = '0;
		top_in    = W'(item.symbol - stkeval_pkg::CH_0);
		apply_en  = 1'b0;
		apply_val = alu_res;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_digit) begin
						if (full) begin
							// Drop the push on a full stack
							if (err_q == stkeval_pkg::ST_OK) begin
								err_d = stkeval_pkg::ST_OVERFLOW;
							end
						end else begin
							top_ctl.take_prev  = 1'b1;
							rest_ctl.take_prev = 1'b1;
							depth_d            = depth_q + DEPTH_W'(1);
						end
					end
					if (is_op) begin
						state_d = S_ALU;
					end else begin
						state_d = item.end_of_expr ? S_EMIT : S_IDLE;
					end
				end
			end
			S_ALU: begin
				if (err_q == stkeval_pkg::ST_OK) begin
					err_d = alu_err;
				end
				if (div_start) begin
					state_d = S_DIV;
				end else begin
					apply_en = 1'b1;
				end
			end
			S_DIV: begin
				if (div_done) begin
					apply_en  = 1'b1;
					apply_val = quotient;
				end
			end
			S_EMIT: begin
				if (emit) begin
					depth_d = '0;
					err_d   = stkeval_pkg::ST_OK;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// Pop two, push one: the first cell takes the result, the rest move up
		if (apply_en) begin
			top_in            = apply_val;
			top_ctl.take_prev = 1'b1;
			rest_ctl.take_next = 1'b1;
			depth_d           = (depth_q > DEPTH_W'(1)) ? (depth_q - DEPTH_W'(1)) : DEPTH_W'(1);
			state_d           = last_q ? S_EMIT : S_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			depth_q     <= '0;
			err_q       <= stkeval_pkg::ST_OK;
			mode_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			err_q   <= err_d;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign depth_wide = 32'(depth_q);

	// Hold the item's operator and end mark; load the result register on emit
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= item.symbol;
			last_q <= item.end_of_expr;
		end
		if (emit) begin
			out_q.value <= (depth_q != '0) ? cells[0] : '0;
			if (err_q != stkeval_pkg::ST_OK) begin
				out_q.status <= err_q;
			end else if (depth_q == '0) begin
				out_q.status <= stkeval_pkg::ST_EMPTY;
			end else begin
				out_q.status <= stkeval_pkg::ST_OK;
			end
			out_q.leftover_depth <= (depth_wide > 32'd127) ? 7'd127 : depth_wide[6:0];
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		logic [W-1:0]           prev_d, next_d;
		stkeval_pkg::cell_ctl_t ctl;

		if (i == 0) begin : g_top
			assign prev_d = top_in;
			assign ctl    = top_ctl;
		end else begin : g_body
			assign prev_d = cells[i-1];
			assign ctl    = rest_ctl;
		end
		if (i == STACK_DEPTH - 1) begin : g_last
			assign next_d = '0;
		end else begin : g_mid
			assign next_d = cells[i+1];
		end

		stkeval_cell u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.prev (prev_d),
			.next (next_d),
			.q    (cells[i])
		);
	end

	stkeval_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (lhs),
		.divisor  (rhs),
		.done     (div_done),
		.quotient (quotient)
	);

endmodule

>>> design/stkeval_chk.sv
// Port-level checker for the stack expression evaluator, bound to the top.
// Depends on stkeval_pkg and stack_expression_evaluator.
module stkeval_chk (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   result_valid,
	input logic                   result_ready,
	input stkeval_pkg::out_item_t result
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result dropped before it was taken");

	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result))
		else $error("result changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.status <= stkeval_pkg::ST_EMPTY)
		else $error("status code out of range");

	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == stkeval_pkg::ST_EMPTY
			|-> result.value == 0 && result.leftover_depth == 7'd0)
		else $error("empty status with a value or depth");

	a_ok_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == stkeval_pkg::ST_OK |-> result.leftover_depth != 7'd0)
		else $error("ok status on an empty stack");

endmodule

bind stack_expression_evaluator stkeval_chk u_chk (.*);

>>> sim/stkeval_checker.sv
// Scoreboard for the stack expression evaluator: watches both item channels and the
// mode register, predicts each expression result and compares it field by field.
// Depends on stkeval_pkg for the item structs, character codes and status codes.
module stkeval_checker #(
	parameter int STACK_DEPTH = stkeval_pkg::STACK_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	input  logic                   item_ready,
	input  stkeval_pkg::in_item_t  item,
	input  logic                   result_valid,
	input  logic                   result_ready,
	input  stkeval_pkg::out_item_t result,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata,
	output int                     mismatches,
	output int                     outstanding
);
	import stkeval_pkg::*;

	logic [DATA_W-1:0] operands [STACK_DEPTH];
	int unsigned       operand_count;
	logic [2:0]        sticky_status;
	logic              prefix_mode;
	out_item_t         expected_results [$];
	out_item_t         oldest;
	int                fail_count;

	function automatic void flag_error(logic [2:0] code);
		if (sticky_status == ST_OK)
			sticky_status = code;
	endfunction

	function automatic logic [DATA_W-1:0] pop_operand();
		if (operand_count == 0) begin
			flag_error(ST_UNDERFLOW);
			return '0;
		end
		operand_count--;
		return operands[operand_count];
	endfunction

	function automatic void push_operand(logic [DATA_W-1:0] v);
		if (operand_count >= STACK_DEPTH) begin
			flag_error(ST_OVERFLOW);
		end else begin
			operands[operand_count] = v;
			operand_count++;
		end
	endfunction

	// Signed quotient truncated toward zero, on magnitudes; min / -1 wraps.
	function automatic logic [DATA_W-1:0] quotient_trunc(logic [DATA_W-1:0] a,
			logic [DATA_W-1:0] b);
		logic [DATA_W-1:0] ma, mb, q;
		ma = a[DATA_W-1] ? -a : a;
		mb = b[DATA_W-1] ? -b : b;
		q  = ma / mb;
		return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
	endfunction

	function automatic void evaluate_symbol(in_item_t it);
		logic [DATA_W-1:0] first_v, second_v, lhs, rhs, res;
		out_item_t         r;
		if (it.symbol >= CH_0 && it.symbol <= CH_9) begin
			push_operand(DATA_W'(it.symbol - CH_0));
		end else if (it.symbol == CH_PLUS || it.symbol == CH_MINUS ||
				it.symbol == CH_STAR || it.symbol == CH_SLASH) begin
			first_v  = pop_operand();
			second_v = pop_operand();
			lhs = prefix_mode ? first_v : second_v;
			rhs = prefix_mode ? second_v : first_v;
			case (it.symbol)
				CH_PLUS:  res = lhs + rhs;
				CH_MINUS: res = lhs - rhs;
				CH_STAR:  res = lhs * rhs;
				default: begin
					if (rhs == '0) begin
						flag_error(ST_DIVZERO);
						res = '0;
					end else begin
						res = quotient_trunc(lhs, rhs);
					end
				end
			endcase
			push_operand(res);
		end
		if (it.end_of_expr) begin
			r.value = (operand_count > 0) ? operands[operand_count - 1] : '0;
			if (sticky_status != ST_OK)
				r.status = sticky_status;
			else if (operand_count == 0)
				r.status = ST_EMPTY;
			else
				r.status = ST_OK;
			r.leftover_depth = (operand_count > 127) ? 7'd127 : 7'(operand_count);
			expected_results.push_back(r);
			operand_count = 0;
			sticky_status = ST_OK;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			operand_count = 0;
			sticky_status = ST_OK;
			prefix_mode   = 1'b0;
			fail_count    = 0;
			expected_results.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_results.size() == 0) begin
					$error("unexpected result: value %0d status %0d depth %0d",
						result.value, result.status, result.leftover_depth);
					fail_count++;
				end else begin
					oldest = expected_results.pop_front();
					if (result.value !== oldest.value) begin
						$error("value: expected %0d, got %0d", oldest.value, result.value);
						fail_count++;
					end
					if (result.status !== oldest.status) begin
						$error("status: expected %0d, got %0d", oldest.status,
							result.status);
						fail_count++;
					end
					if (result.leftover_depth !== oldest.leftover_depth) begin
						$error("leftover_depth: expected %0d, got %0d",
							oldest.leftover_depth, result.leftover_depth);
						fail_count++;
					end
				end
			end
			if (cfg_we)
				prefix_mode = cfg_wdata;
			if (item_valid && item_ready)
				evaluate_symbol(item);
			mismatches  <= fail_count;
			outstanding <= expected_results.size();
		end
	end

endmodule

>>> sim/tb.sv
// Top of the evaluator testbench: clock, reset, expression stimulus, result stalls
// and the verdict. Depends on stkeval_pkg, stack_expression_evaluator and
// stkeval_checker, which does all prediction and comparison.
module tb;
	import stkeval_pkg::*;

	localparam int ITEMS_TOTAL = 1800;
	localparam int PHASES      = 5;
	localparam int CYCLE_LIMIT = 600000;
	// Longest single operation is a division plus hand-off.
	localparam int DRAIN_CYCLES = 60;
	localparam int LONG_HOLD    = 500;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_item_t  item;
	logic      result_valid;
	logic      result_ready;
	out_item_t result;
	logic      cfg_we;
	logic      cfg_wdata;
	int        mismatches;
	int        outstanding;

	int          cycle_count = 0;
	int          live_items = 0;
	logic        quiet = 1'b0;
	logic        gaps_on = 1'b1;
	logic        notation = 1'b0;
	logic [7:0]  expr_chars [$];

	always #5 clk = ~clk;

	stack_expression_evaluator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	stkeval_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Offer one item and hold it until the block takes it; optionally idle first.
	task automatic send_item(input logic [7:0] sym, input logic last);
		in_item_t next;
		next.symbol      = sym;
		next.end_of_expr = last;
		if (!quiet && gaps_on && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= next;
		@(posedge clk);
		while (!item_ready) @(posedge clk);
	endtask

	// Send the built expression; the last character carries the end mark.
	task automatic send_expr();
		for (int i = 0; i < expr_chars.size(); i++) begin
			if ((expr_chars[i] >= CH_0 && expr_chars[i] <= CH_9) ||
					expr_chars[i] == CH_PLUS || expr_chars[i] == CH_MINUS ||
					expr_chars[i] == CH_STAR || expr_chars[i] == CH_SLASH)
				live_items++;
			send_item(expr_chars[i], i == expr_chars.size() - 1);
		end
		expr_chars.delete();
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			expr_chars.push_back(s[i]);
		send_expr();
	endtask

	// Drop valid, wait for every pending result, then let any divide finish.
	task automatic settle();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		notation  = m;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] pick_digit();
		return CH_0 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_op();
		case ($urandom_range(0, 3))
			0:       return CH_PLUS;
			1:       return CH_MINUS;
			2:       return CH_STAR;
			default: return CH_SLASH;
		endcase
	endfunction

	// Build one random expression: mostly well-formed, some broken, noisy,
	// stack-filling or built around the most negative value.
	function automatic void build_random_expr();
		int kind, n_ops, done, level, count;
		kind = $urandom_range(0, 99);
		if (kind < 65) begin
			// Well-formed tree in postfix shape; valid in either mode.
			n_ops = $urandom_range(0, 12);
			done  = 0;
			level = 0;
			while (done < n_ops || level != 1) begin
				if (level >= 2 && (done >= n_ops || $urandom_range(0, 1) == 0)) begin
					expr_chars.push_back(pick_op());
					level--;
					done++;
				end else begin
					expr_chars.push_back(pick_digit());
					level++;
				end
				if ($urandom_range(0, 19) == 0)
					expr_chars.push_back(8'($urandom_range(0, 255)));
			end
		end else if (kind < 80) begin
			// Broken: unstructured digits and operators, underflow and leftovers.
			count = $urandom_range(1, 12);
			repeat (count)
				expr_chars.push_back($urandom_range(0, 1) ? pick_op() : pick_digit());
		end else if (kind < 88) begin
			// Noise over the whole byte range.
			count = $urandom_range(1, 8);
			repeat (count)
				expr_chars.push_back(8'($urandom_range(0, 255)));
		end else if (kind < 95) begin
			// Fill the stack close to or past its depth.
			count = $urandom_range(55, 70);
			repeat (count)
				expr_chars.push_back(pick_digit());
			count = $urandom_range(0, 5);
			repeat (count)
				expr_chars.push_back(pick_op());
		end else begin
			// Most negative value divided by minus one; operand order per mode.
			if (notation) begin
				expr_chars.push_back(CH_0 + 8'd1);
				expr_chars.push_back(CH_0);
				expr_chars.push_back(CH_MINUS);
			end
			expr_chars.push_back(CH_0 + 8'd2);
			repeat (30) begin
				expr_chars.push_back(CH_0 + 8'd2);
				expr_chars.push_back(CH_STAR);
			end
			if (!notation) begin
				expr_chars.push_back(CH_0);
				expr_chars.push_back(CH_0 + 8'd1);
				expr_chars.push_back(CH_MINUS);
			end
			expr_chars.push_back(CH_SLASH);
		end
	endfunction

	// Result side: random short stalls, one long hold-off, none at the end.
	initial begin
		int seen;
		int stall;
		logic long_done;
		result_ready = 1'b0;
		seen         = 0;
		long_done    = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (!quiet && !long_done && seen >= 30) begin
				long_done = 1'b1;
				result_ready <= 1'b0;
				stall = 0;
				while (stall < LONG_HOLD) begin
					@(posedge clk);
					stall++;
				end
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 4)) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
			if (result_valid && result_ready)
				seen++;
		end
	end

	initial begin
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, postfix from reset: each operator, divide by zero,
		// underflow on an empty stack, end on an ignored character.
		send_text("34+");
		send_text("92-");
		send_text("57*");
		send_text("82/");
		send_text("50/");
		send_text("+");
		send_text("z");
		send_text("9");
		settle();

		// Directed, prefix: check the swapped operand order.
		write_mode(1'b1);
		send_text("29-");
		send_text("28/");

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			write_mode(phase % 2 == 1);
			if (phase == PHASES - 1)
				quiet = 1'b1;
			while (live_items < (phase + 1) * ITEMS_TOTAL / PHASES) begin
				gaps_on = ($urandom_range(0, 3) != 0);
				build_random_expr();
				// Send it; after the loop a single digit closes the phase so it ends on a result.
				send_expr();
			end
			expr_chars.push_back(pick_digit());
			send_expr();
		end
		settle();

		if (mismatches == 0 && outstanding == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
